>>> sv/pc_sample_histogram_assert.svh
// concurrent assertion helpers for the profiler
`ifndef PC_SAMPLE_HISTOGRAM_ASSERT_SVH
`define PC_SAMPLE_HISTOGRAM_ASSERT_SVH
`ifndef SYNTH
`define PCSH_ASSERT_IMP(label, clk, rst, pre, post, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
      else $error(msg);
`define PCSH_ASSERT_NEXT(label, clk, rst, pre, post, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error(msg);
`else
`define PCSH_ASSERT_IMP(label, clk, rst, pre, post, msg)
`define PCSH_ASSERT_NEXT(label, clk, rst, pre, post, msg)
`endif
`endif

>>> sv/pcsh_pkg.sv
`default_nettype none
package pcsh_pkg;

   localparam int BUCKETS     = 32768;
   localparam int IDX_W       = $clog2(BUCKETS);
   localparam int ADDR_W      = 32;
   localparam int COUNT_W     = 32;
   localparam int OP_W        = 2;
   localparam int CSR_IDX_W   = 1;
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

   localparam logic [ADDR_W-1:0] ADDR_LOW_RESET  = 32'd0;
   localparam logic [ADDR_W-1:0] ADDR_HIGH_RESET = 32'd131072;

   typedef enum logic [OP_W-1:0] {
      OP_SAMPLE = 2'd0,
      OP_CLEAR  = 2'd1,
      OP_READ   = 2'd2
   } op_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_ADDR_LOW  = 1'd0,
      CSR_ADDR_HIGH = 1'd1
   } csr_index_type;

   // classified work for the back end
   typedef enum logic [1:0] {
      ACT_MISS   = 2'd0,
      ACT_SAMPLE = 2'd1,
      ACT_READ   = 2'd2,
      ACT_CLEAR  = 2'd3
   } act_type;

   typedef struct packed {
      act_type          act;
      logic [IDX_W-1:0] index;
   } entry_type;

endpackage
`default_nettype wire

>>> sv/pc_sample_histogram.sv
// Program-counter sampling histogram. Each item is a sample, a clear or a read. A sample whose
// address falls in [addr_low, addr_high) bumps the 32-bit counter of its word bucket and returns
// the new count; a read returns the count; misses, clears and the unused operation code return
// zero with rsp_in_window low. Items pass the window check on entry and wait in a four-deep
// queue for the bucket store, a single-port RAM with registered read. A sample or read that
// hits reads its bucket, then loads the result and, for a sample, writes the new count back;
// a miss loads its result straight from the idle state, and a clear writes zero to every
// bucket before it loads its result. After reset the store is swept to zero, during which
// req_ready stays low. The back end takes no new item while a result waits on rsp_ready.
// Configuration is to be written only while no item is in flight.
`default_nettype none
module pc_sample_histogram
   import pcsh_pkg::*;
(
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 csr_valid,
   output logic                      csr_ready,
   input  wire logic [CSR_IDX_W-1:0] csr_index,
   input  wire logic [ADDR_W-1:0]    csr_data,
   input  wire logic                 req_valid,
   output logic                      req_ready,
   input  wire logic [OP_W-1:0]      req_operation,
   input  wire logic [ADDR_W-1:0]    req_address,
   output logic                      rsp_valid,
   input  wire logic                 rsp_ready,
   output logic      [COUNT_W-1:0]   rsp_count,
   output logic                      rsp_in_window
);

   entry_type entry;
   entry_type head;
   logic      push;
   logic      pop;
   logic      full;
   logic      empty;
   logic      init_done;

   assign req_ready = !full && init_done;
   assign push      = req_valid && req_ready;

   pcsh_front u_front (
      .clock         (clock),
      .reset         (reset),
      .csr_valid     (csr_valid),
      .csr_ready     (csr_ready),
      .csr_index     (csr_index),
      .csr_data      (csr_data),
      .req_operation (req_operation),
      .req_address   (req_address),
      .entry         (entry)
   );

   pcsh_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (entry),
      .pop        (pop),
      .head       (head),
      .full       (full),
      .empty      (empty)
   );

   pcsh_back u_back (
      .clock         (clock),
      .reset         (reset),
      .head          (head),
      .empty         (empty),
      .pop           (pop),
      .init_done     (init_done),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_count     (rsp_count),
      .rsp_in_window (rsp_in_window)
   );

endmodule
`default_nettype wire

>>> sv/pcsh_ram.sv
`default_nettype none
module pcsh_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024
) (
   input  wire logic                     clock,
   input  wire logic                     en,
   input  wire logic                     we,
   input  wire logic [$clog2(DEPTH)-1:0] addr,
   input  wire logic [WIDTH-1:0]         wdata,
   output logic      [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (en) begin
         if (we) begin
            mem_ff[addr] <= wdata;
         end else begin
            rdata <= mem_ff[addr];
         end
      end
   end

endmodule
`default_nettype wire

>>> sv/pcsh_front.sv
`default_nettype none
module pcsh_front
   import pcsh_pkg::*;
(
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 csr_valid,
   output logic                      csr_ready,
   input  wire logic [CSR_IDX_W-1:0] csr_index,
   input  wire logic [ADDR_W-1:0]    csr_data,
   input  wire logic [OP_W-1:0]      req_operation,
   input  wire logic [ADDR_W-1:0]    req_address,
   output entry_type                 entry
);

   logic [ADDR_W-1:0] addr_low_ff;
   logic [ADDR_W-1:0] addr_low_in;
   logic [ADDR_W-1:0] addr_high_ff;
   logic [ADDR_W-1:0] addr_high_in;
   logic [ADDR_W-1:0] offset;
   logic              in_range;

   assign csr_ready = 1'b1;

   always_comb begin
      addr_low_in  = addr_low_ff;
      addr_high_in = addr_high_ff;
      if (csr_valid) begin
         unique case (csr_index)
            CSR_ADDR_LOW:  addr_low_in  = csr_data;
            CSR_ADDR_HIGH: addr_high_in = csr_data;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         addr_low_ff  <= ADDR_LOW_RESET;
         addr_high_ff <= ADDR_HIGH_RESET;
      end else begin
         addr_low_ff  <= addr_low_in;
         addr_high_ff <= addr_high_in;
      end
   end

   // window check and word bucket
   always_comb begin
      offset   = req_address - addr_low_ff;
      in_range = (req_address >= addr_low_ff) && (req_address < addr_high_ff)
                 && ({2'b00, offset[ADDR_W-1:2]} < ADDR_W'(BUCKETS));
      entry.index = offset[IDX_W+1:2];
      unique case (req_operation)
         OP_SAMPLE: entry.act = in_range ? ACT_SAMPLE : ACT_MISS;
         OP_CLEAR:  entry.act = ACT_CLEAR;
         OP_READ:   entry.act = in_range ? ACT_READ : ACT_MISS;
         default:   entry.act = ACT_MISS;
      endcase
   end

endmodule
`default_nettype wire

>>> sv/pcsh_queue.sv
`default_nettype none
module pcsh_queue
   import pcsh_pkg::*;
(
   input  wire logic      clock,
   input  wire logic      reset,
   input  wire logic      push,
   input  wire entry_type push_entry,
   input  wire logic      pop,
   output entry_type      head,
   output logic           full,
   output logic           empty
);

   entry_type         entries_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff;
   logic [QPTR_W-1:0] wr_ptr_in;
   logic [QPTR_W-1:0] rd_ptr_ff;
   logic [QPTR_W-1:0] rd_ptr_in;
   logic [QPTR_W:0]   count_ff;
   logic [QPTR_W:0]   count_in;

   assign full  = (count_ff == (QPTR_W+1)'(QUEUE_DEPTH));
   assign empty = (count_ff == '0);
   assign head  = entries_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == QPTR_W'(QUEUE_DEPTH-1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == QPTR_W'(QUEUE_DEPTH-1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule
`default_nettype wire

>>> sv/pcsh_back.sv
`default_nettype none
`include "pc_sample_histogram_assert.svh"
module pcsh_back
   import pcsh_pkg::*;
(
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire entry_type          head,
   input  wire logic               empty,
   output logic                    pop,
   output logic                    init_done,
   output logic                    rsp_valid,
   input  wire logic               rsp_ready,
   output logic      [COUNT_W-1:0] rsp_count,
   output logic                    rsp_in_window
);

   typedef enum logic [3:0] {
      ST_INIT  = 4'b0001,
      ST_IDLE  = 4'b0010,
      ST_LOOK  = 4'b0100,
      ST_CLEAR = 4'b1000
   } state_type;

   state_type          state_ff;
   state_type          state_in;
   logic [IDX_W-1:0]   clr_addr_ff;
   logic [IDX_W-1:0]   clr_addr_in;
   entry_type          cur_ff;
   entry_type          cur_in;
   logic               rsp_valid_ff;
   logic               rsp_valid_in;
   logic [COUNT_W-1:0] rsp_count_ff;
   logic               rsp_hit_ff;

   logic               slot_free;
   logic               clr_last;
   logic               out_load;
   logic [COUNT_W-1:0] out_count;
   logic               out_hit;
   logic               ram_en;
   logic               ram_we;
   logic [IDX_W-1:0]   ram_addr;
   logic [COUNT_W-1:0] ram_wdata;
   logic [COUNT_W-1:0] ram_rdata;

   pcsh_ram #(
      .WIDTH (COUNT_W),
      .DEPTH (BUCKETS)
   ) u_ram (
      .clock (clock),
      .en    (ram_en),
      .we    (ram_we),
      .addr  (ram_addr),
      .wdata (ram_wdata),
      .rdata (ram_rdata)
   );

   assign slot_free     = !rsp_valid_ff || rsp_ready;
   assign clr_last      = (clr_addr_ff == IDX_W'(BUCKETS-1));
   assign init_done     = (state_ff != ST_INIT);
   assign rsp_valid     = rsp_valid_ff;
   assign rsp_count     = rsp_count_ff;
   assign rsp_in_window = rsp_hit_ff;

   always_comb begin
      state_in    = state_ff;
      clr_addr_in = clr_addr_ff;
      cur_in      = cur_ff;
      pop         = 1'b0;
      out_load    = 1'b0;
      out_count   = '0;
      out_hit     = 1'b0;
      ram_en      = 1'b0;
      ram_we      = 1'b0;
      ram_addr    = cur_ff.index;
      ram_wdata   = '0;
      unique case (state_ff)
         ST_INIT, ST_CLEAR: begin
            ram_en      = 1'b1;
            ram_we      = 1'b1;
            ram_addr    = clr_addr_ff;
            clr_addr_in = clr_addr_ff + 1'b1;
            if (clr_last) begin
               clr_addr_in = '0;
               out_load    = (state_ff == ST_CLEAR);
               state_in    = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (!empty && slot_free) begin
               pop    = 1'b1;
               cur_in = head;
               unique case (head.act) inside
                  ACT_SAMPLE, ACT_READ: begin
                     ram_en   = 1'b1;
                     ram_addr = head.index;
                     state_in = ST_LOOK;
                  end
                  ACT_CLEAR: state_in = ST_CLEAR;
                  default:   out_load = 1'b1;
               endcase
            end
         end
         ST_LOOK: begin
            out_load = 1'b1;
            out_hit  = 1'b1;
            if (cur_ff.act == ACT_SAMPLE) begin
               out_count = ram_rdata + 1'b1;
               ram_en    = 1'b1;
               ram_we    = 1'b1;
               ram_wdata = out_count;
            end else begin
               out_count = ram_rdata;
            end
            state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
      rsp_valid_in = out_load || (rsp_valid_ff && !rsp_ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_INIT;
         clr_addr_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_addr_ff  <= clr_addr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff <= cur_in;
      if (out_load) begin
         rsp_count_ff <= out_count;
         rsp_hit_ff   <= out_hit;
      end
   end

   `PCSH_ASSERT_IMP(a_look_slot_free, clock, reset, state_ff == ST_LOOK,
      !rsp_valid_ff, "result slot busy during lookup")
   `PCSH_ASSERT_NEXT(a_look_gives_item, clock, reset, state_ff == ST_LOOK,
      rsp_valid_ff && rsp_hit_ff, "lookup gave no item")
   `PCSH_ASSERT_IMP(a_pop_when_idle, clock, reset, pop,
      (state_ff == ST_IDLE) && !empty, "pop outside idle or from empty queue")
   `PCSH_ASSERT_IMP(a_write_not_idle, clock, reset, ram_we,
      state_ff != ST_IDLE, "store written while idle")
   `PCSH_ASSERT_NEXT(a_clear_done_gives_item, clock, reset, (state_ff == ST_CLEAR) && clr_last,
      rsp_valid_ff && !rsp_hit_ff, "clear gave no item")

endmodule
`default_nettype wire

>>> dv/tb.sv
`timescale 1ns / 100ps

import pcsh_pkg::*;

class pc_profile_tracker;
   logic [ADDR_W-1:0]  window_low;
   logic [ADDR_W-1:0]  window_high;
   logic [COUNT_W-1:0] tally [int unsigned];
   logic [COUNT_W:0]   awaited [$];   // {in_window, count}
   int                 faults;
   int                 reported;

   function new();
      window_low  = ADDR_LOW_RESET;
      window_high = ADDR_HIGH_RESET;
      faults      = 0;
      reported    = 0;
   endfunction

   function void set_reg(csr_index_type which, logic [ADDR_W-1:0] data);
      if (which == CSR_ADDR_LOW) begin
         window_low = data;
      end else begin
         window_high = data;
      end
   endfunction

   function bit find_bucket(logic [ADDR_W-1:0] a, output int unsigned slot);
      logic [ADDR_W-1:0] offset;
      slot = 0;
      if (a < window_low || a >= window_high) return 1'b0;
      offset = (a - window_low) >> 2;
      if (offset >= BUCKETS) return 1'b0;
      slot = offset;
      return 1'b1;
   endfunction

   function void note_item(logic [OP_W-1:0] op, logic [ADDR_W-1:0] a);
      int unsigned        slot;
      logic [COUNT_W-1:0] value;
      bit                 hit;
      value = '0;
      hit   = 1'b0;
      if (op == OP_CLEAR) begin
         tally.delete();
      end else if (op == OP_SAMPLE || op == OP_READ) begin
         hit = find_bucket(a, slot);
         if (hit) begin
            value = tally.exists(slot) ? tally[slot] : '0;
            if (op == OP_SAMPLE) begin
               value += 1'b1;
               tally[slot] = value;
            end
         end
      end
      awaited.push_back({hit, value});
   endfunction

   function void flag(string msg);
      faults++;
      if (reported < 10) begin
         reported++;
         $display("mismatch: %s", msg);
      end
   endfunction

   function void check_result(logic [COUNT_W-1:0] count, logic in_window);
      logic [COUNT_W:0] want;
      if (awaited.size() == 0) begin
         flag($sformatf("unexpected item: count %h in_window %b", count, in_window));
         return;
      end
      want = awaited.pop_front();
      if (want !== {in_window, count}) begin
         flag($sformatf("count expected %h actual %h, in_window expected %b actual %b",
                        want[COUNT_W-1:0], count, want[COUNT_W], in_window));
      end
   endfunction
endclass

module tb;
   localparam logic [OP_W-1:0] OP_UNUSED      = 2'd3;
   localparam int              WATCHDOG_LIMIT = 200000;

   logic                 clock         = 1'b0;
   logic                 reset         = 1'b1;
   logic                 csr_valid     = 1'b0;
   logic                 csr_ready;
   logic [CSR_IDX_W-1:0] csr_index     = CSR_ADDR_LOW;
   logic [ADDR_W-1:0]    csr_data      = '0;
   logic                 req_valid     = 1'b0;
   logic                 req_ready;
   logic [OP_W-1:0]      req_operation = OP_SAMPLE;
   logic [ADDR_W-1:0]    req_address   = '0;
   logic                 rsp_valid;
   logic                 rsp_ready     = 1'b0;
   logic [COUNT_W-1:0]   rsp_count;
   logic                 rsp_in_window;

   int tx_idle_pct  = 0;
   int rx_idle_pct  = 0;
   int quiet_cycles = 0;

   pc_profile_tracker profile = new();

   pc_sample_histogram u_top (
      .clock         (clock),
      .reset         (reset),
      .csr_valid     (csr_valid),
      .csr_ready     (csr_ready),
      .csr_index     (csr_index),
      .csr_data      (csr_data),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_operation (req_operation),
      .req_address   (req_address),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_count     (rsp_count),
      .rsp_in_window (rsp_in_window)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      rsp_ready <= ($urandom_range(99) >= rx_idle_pct);
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (csr_valid && csr_ready) profile.set_reg(csr_index_type'(csr_index), csr_data);
         if (req_valid && req_ready) profile.note_item(req_operation, req_address);
         if (rsp_valid && rsp_ready) profile.check_result(rsp_count, rsp_in_window);
      end
   end

   always @(posedge clock) begin
      if (reset || (csr_valid && csr_ready) || (req_valid && req_ready) ||
          (rsp_valid && rsp_ready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("pc_sample_histogram regression: fail");
         $finish;
      end
   end

   task automatic send_item(input logic [OP_W-1:0] op, input logic [ADDR_W-1:0] a);
      if ($urandom_range(99) < tx_idle_pct) begin
         req_valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < tx_idle_pct);
      end
      req_valid     <= 1'b1;
      req_operation <= op;
      req_address   <= a;
      do @(posedge clock); while (!req_ready);
   endtask

   task automatic wait_for_results();
      req_valid <= 1'b0;
      do @(posedge clock); while (profile.awaited.size() != 0);
   endtask

   task automatic write_reg(input csr_index_type which, input logic [ADDR_W-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= which;
      csr_data  <= data;
      do @(posedge clock); while (!csr_ready);
   endtask

   task automatic set_window(input logic [ADDR_W-1:0] lo, input logic [ADDR_W-1:0] hi);
      wait_for_results();
      write_reg(CSR_ADDR_LOW, lo);
      write_reg(CSR_ADDR_HIGH, hi);
      csr_valid <= 1'b0;
   endtask

   function automatic logic [OP_W-1:0] pick_operation();
      int unsigned roll;
      roll = $urandom_range(999);
      if (roll < 7) return OP_CLEAR;
      if (roll < 40) return OP_UNUSED;
      if (roll < 600) return OP_SAMPLE;
      return OP_READ;
   endfunction

   // mostly a few hot buckets so the counts climb, then random window addresses, window edges and noise
   function automatic logic [ADDR_W-1:0] pick_address(logic [ADDR_W-1:0] lo,
                                                      logic [ADDR_W-1:0] hi);
      logic [ADDR_W-1:0] span;
      int unsigned       pick;
      span = (hi > lo) ? hi - lo : 32'd64;
      pick = $urandom_range(99);
      if (pick < 70) return lo + 4 * $urandom_range(0, 15) + $urandom_range(0, 3);
      if (pick < 80) return lo + $urandom % span;
      if (pick < 92) begin
         case ($urandom_range(0, 5))
            0:       return lo;
            1:       return lo - 1;
            2:       return hi;
            3:       return hi - 1;
            4:       return lo + 4 * BUCKETS;
            default: return lo + 4 * BUCKETS - 1;
         endcase
      end
      return $urandom;
   endfunction

   task automatic run_phase(input logic [ADDR_W-1:0] lo, input logic [ADDR_W-1:0] hi,
                            input int items);
      set_window(lo, hi);
      for (int n = 0; n < items; n++) begin
         if (n == items / 2) wait_for_results();
         send_item(pick_operation(), pick_address(lo, hi));
      end
   endtask

   initial begin
      logic [ADDR_W-1:0] base;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // default window after reset
      send_item(OP_READ,   32'h0000_0000);
      send_item(OP_SAMPLE, 32'h0000_0000);
      send_item(OP_SAMPLE, 32'h0000_0003);
      send_item(OP_SAMPLE, 32'h0001_FFFF);
      send_item(OP_SAMPLE, 32'h0002_0000);
      send_item(OP_SAMPLE, 32'hFFFF_FFFF);
      send_item(OP_READ,   32'h0001_FFFC);
      send_item(OP_UNUSED, 32'h0000_0000);
      send_item(OP_UNUSED, 32'hFFFF_FFFF);
      send_item(OP_CLEAR,  32'h0000_0000);
      send_item(OP_READ,   32'h0000_0000);
      send_item(OP_READ,   32'h0001_FFFF);

      // window wider than the bucket store
      set_window(32'h0000_0000, 32'hFFFF_FFFF);
      send_item(OP_SAMPLE, 32'h0002_0000);
      send_item(OP_SAMPLE, 32'h0001_FFFC);
      send_item(OP_READ,   32'hFFFF_FFFE);

      // window at the top of the address space
      set_window(32'hFFFF_8000, 32'hFFFF_FFFF);
      send_item(OP_SAMPLE, 32'hFFFF_8000);
      send_item(OP_SAMPLE, 32'hFFFF_FFFE);
      send_item(OP_SAMPLE, 32'hFFFF_FFFF);
      send_item(OP_SAMPLE, 32'hFFFF_7FFF);

      // inverted and empty windows
      set_window(32'hFFFF_FFFF, 32'h0000_0000);
      send_item(OP_SAMPLE, 32'h0000_0000);
      send_item(OP_READ,   32'hFFFF_FFFF);
      set_window(32'h0000_1000, 32'h0000_1000);
      send_item(OP_SAMPLE, 32'h0000_1000);

      tx_idle_pct = 29;
      rx_idle_pct = 57;
      run_phase(32'h0000_4000, 32'h0000_4400, 125);
      run_phase(32'h8000_0000, 32'h8002_0000, 125);

      tx_idle_pct = 57;
      rx_idle_pct = 29;
      base = $urandom;
      run_phase(base, base + $urandom_range(64, 4096), 125);
      run_phase(32'hFFFF_F000, 32'hFFFF_FFFF, 125);

      tx_idle_pct = 0;
      rx_idle_pct = 0;
      run_phase(32'h0000_0000, 32'hFFFF_FFFF, 125);
      base = $urandom;
      run_phase(base, $urandom_range(0, base), 60);

      wait_for_results();
      repeat (20) @(posedge clock);
      if (profile.faults == 0 && profile.awaited.size() == 0) begin
         $display("pc_sample_histogram regression: pass");
      end else begin
         $display("pc_sample_histogram regression: fail");
      end
      $finish;
   end
endmodule
